// File: sv/ppd_pkg.sv
package ppd_pkg;

   // internal values: sign plus 60-bit magnitude, clamped to +-(2^60-1)
   localparam int VAL_W = 61;
   localparam int MAG_W = 60;
   localparam logic [MAG_W-1:0] LIM_MAG = {MAG_W{1'b1}};
   localparam logic signed [63:0] LIM64 = 64'sh0FFF_FFFF_FFFF_FFFF;

   localparam int CFG_W = 32;
   localparam int CFG_ADDR_W = 3;

   localparam logic [CFG_ADDR_W-1:0] REG_FOCAL_X = 3'd0;
   localparam logic [CFG_ADDR_W-1:0] REG_FOCAL_Y = 3'd1;
   localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X = 3'd2;
   localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y = 3'd3;
   localparam logic [CFG_ADDR_W-1:0] REG_RADIAL_K1 = 3'd4;
   localparam logic [CFG_ADDR_W-1:0] REG_RADIAL_K2 = 3'd5;
   localparam logic [CFG_ADDR_W-1:0] REG_TANGENTIAL_P1 = 3'd6;
   localparam logic [CFG_ADDR_W-1:0] REG_TANGENTIAL_P2 = 3'd7;

   typedef logic signed [VAL_W-1:0] val_type;

   typedef struct packed {
      logic sat;
      logic signed [VAL_W-1:0] val;
   } cval_type;

   function automatic cval_type clamp_val(input logic signed [63:0] v);
      cval_type r;
      if (v > LIM64) begin
         r.sat = 1'b1;
         r.val = VAL_W'(LIM64);
      end else if (v < -LIM64) begin
         r.sat = 1'b1;
         r.val = VAL_W'(-LIM64);
      end else begin
         r.sat = 1'b0;
         r.val = VAL_W'(v);
      end
      return r;
   endfunction

endpackage

// File: sv/ppd_delay.sv
module ppd_delay #(
   parameter int W = 8,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);
   logic [W-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign q = tap_ff[DEPTH-1];
endmodule

// File: sv/ppd_fmul.sv
// (a*b) >> FRAC on magnitudes, clamped, four register stages
module ppd_fmul #(
   parameter int FRAC = 28
) (
   input  logic             clock,
   input  logic             en,
   input  ppd_pkg::val_type a,
   input  ppd_pkg::val_type b,
   output ppd_pkg::val_type q,
   output logic             sat
);
   import ppd_pkg::*;

   localparam int HW = MAG_W / 2;
   localparam int PW = 2 * MAG_W;

   logic [MAG_W-1:0] ma_ff, mb_ff, ma_in, mb_in;
   logic [2:0]       neg_ff;
   logic [MAG_W-1:0] pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [MAG_W-1:0] pp_ll_in, pp_lh_in, pp_hl_in, pp_hh_in;
   logic [PW-1:0]    sum_ff, sum_in, shifted;
   logic [MAG_W-1:0] mag;
   val_type          q_ff, q_in;
   logic             sat_ff, sat_in;

   assign ma_in = a[VAL_W-1] ? MAG_W'(-a) : a[MAG_W-1:0];
   assign mb_in = b[VAL_W-1] ? MAG_W'(-b) : b[MAG_W-1:0];

   assign pp_ll_in = {{HW{1'b0}}, ma_ff[HW-1:0]} * {{HW{1'b0}}, mb_ff[HW-1:0]};
   assign pp_lh_in = {{HW{1'b0}}, ma_ff[HW-1:0]} * {{HW{1'b0}}, mb_ff[MAG_W-1:HW]};
   assign pp_hl_in = {{HW{1'b0}}, ma_ff[MAG_W-1:HW]} * {{HW{1'b0}}, mb_ff[HW-1:0]};
   assign pp_hh_in = {{HW{1'b0}}, ma_ff[MAG_W-1:HW]} * {{HW{1'b0}}, mb_ff[MAG_W-1:HW]};

   assign sum_in = PW'(pp_ll_ff) + (PW'(pp_lh_ff) << HW) + (PW'(pp_hl_ff) << HW)
                 + (PW'(pp_hh_ff) << MAG_W);

   assign shifted = sum_ff >> FRAC;
   assign sat_in  = |shifted[PW-1:MAG_W];
   assign mag     = sat_in ? LIM_MAG : shifted[MAG_W-1:0];
   assign q_in    = neg_ff[2] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff    <= ma_in;
         mb_ff    <= mb_in;
         neg_ff   <= {neg_ff[1:0], a[VAL_W-1] ^ b[VAL_W-1]};
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
         pp_hh_ff <= pp_hh_in;
         sum_ff   <= sum_in;
         q_ff     <= q_in;
         sat_ff   <= sat_in;
      end
   end

   assign q   = q_ff;
   assign sat = sat_ff;
endmodule

// File: sv/ppd_div.sv
// restoring divider, one quotient bit per stage
module ppd_div #(
   parameter int NW = 60,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [NW-1:0] quo
);
   logic [DW-1:0] rem_ff [NW];
   logic [DW-1:0] rem_in [NW];
   logic [NW-1:0] nq_ff  [NW];
   logic [NW-1:0] nq_in  [NW];
   logic [DW-1:0] den_ff [NW];
   logic [DW-1:0] den_in [NW];

   always_comb begin
      logic [DW-1:0] src_rem;
      logic [NW-1:0] src_nq;
      logic [DW:0]   tmp;
      logic [DW:0]   diff;
      logic          ge;
      for (int i = 0; i < NW; i++) begin
         if (i == 0) begin
            src_rem   = '0;
            src_nq    = num;
            den_in[i] = den;
         end else begin
            src_rem   = rem_ff[i-1];
            src_nq    = nq_ff[i-1];
            den_in[i] = den_ff[i-1];
         end
         tmp       = {src_rem, src_nq[NW-1]};
         diff      = tmp - {1'b0, den_in[i]};
         ge        = tmp >= {1'b0, den_in[i]};
         rem_in[i] = ge ? diff[DW-1:0] : tmp[DW-1:0];
         nq_in[i]  = {src_nq[NW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NW; i++) begin
            rem_ff[i] <= rem_in[i];
            nq_ff[i]  <= nq_in[i];
            den_ff[i] <= den_in[i];
         end
      end
   end

   assign quo = nq_ff[NW-1];
endmodule

// File: sv/project_point_with_lens_distortion_top.sv
// Pinhole projection with Brown-Conrady distortion (k1, k2, p1, p2).
// req_ channel: one camera-frame point per item (x, y, depth, Q16.16).
// rsp_ channel: one pixel per item (u, v, Q16.16) with an invalid flag in
// tuser; invalid marks depth <= 0 (u = v = 0) or any saturation.
// csr_ port: write-only register file; the user must write it only while the
// block is idle, which the block does not enforce. Throughput: one item per
// cycle while the receiver keeps taking results. The bit-per-stage divider
// for x/z and y/z is followed by five rounds of four-stage multipliers, with
// a clamp/add stage after each round but the second.
// The whole pipe moves on one enable: when the last stage holds an item the
// receiver has not taken, every stage holds and req_tready drops, so nothing
// is lost or repeated. Bubbles travel with their valid bit.
// Reset clears the valid bits and loads focal = 1.0, all else 0; there is no
// clearing pass and an item may be sent in the first cycle after reset.
module project_point_with_lens_distortion_top #(
   parameter int COORD_WIDTH = 32,
   parameter int COEF_FRAC_BITS = 28
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // point_x, point_y, point_z from bit 0 up
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]        req_tdata,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // pixel_u, pixel_v from bit 0 up
   output logic [((2*COORD_WIDTH+7)/8)*8-1:0]        rsp_tdata,
   // invalid
   output logic                                      rsp_tuser,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   input  logic                                      csr_we,
   input  logic [ppd_pkg::CFG_ADDR_W-1:0]            csr_addr,
   input  logic [ppd_pkg::CFG_W-1:0]                 csr_wdata
);
   import ppd_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int F = COEF_FRAC_BITS;
   localparam int NW = CW + F;
   localparam int ML = 4;                   // multiplier latency
   localparam int LAT = NW + 5*ML + 6;
   localparam int RSP_W = ((2*CW+7)/8)*8;
   localparam logic signed [63:0] CMAX = (64'sd1 <<< (CW-1)) - 64'sd1;
   localparam logic signed [63:0] CMIN = -CMAX - 64'sd1;

   // ---------------- configuration ----------------
   logic [31:0]        fx_ff, fy_ff;
   logic signed [31:0] cx_ff, cy_ff, k1_ff, k2_ff, p1_ff, p2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fx_ff <= 32'd65536;
         fy_ff <= 32'd65536;
         cx_ff <= '0;
         cy_ff <= '0;
         k1_ff <= '0;
         k2_ff <= '0;
         p1_ff <= '0;
         p2_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_FOCAL_X:       fx_ff <= csr_wdata;
            REG_FOCAL_Y:       fy_ff <= csr_wdata;
            REG_CENTER_X:      cx_ff <= $signed(csr_wdata);
            REG_CENTER_Y:      cy_ff <= $signed(csr_wdata);
            REG_RADIAL_K1:     k1_ff <= $signed(csr_wdata);
            REG_RADIAL_K2:     k2_ff <= $signed(csr_wdata);
            REG_TANGENTIAL_P1: p1_ff <= $signed(csr_wdata);
            REG_TANGENTIAL_P2: p2_ff <= $signed(csr_wdata);
            default:           fx_ff <= fx_ff;
         endcase
      end
   end

   // ---------------- flow control ----------------
   logic [LAT-1:0] vld_ff;
   logic           en;

   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // ---------------- input stage: magnitudes, depth check ----------------
   logic signed [CW-1:0] req_x, req_y, req_z;
   logic [CW-1:0]        ax_ff, ay_ff, z_ff;
   logic [2:0]           flag_ff, flag_div;     // sign x, sign y, bad depth

   assign req_x = $signed(req_tdata[CW-1:0]);
   assign req_y = $signed(req_tdata[2*CW-1:CW]);
   assign req_z = $signed(req_tdata[3*CW-1:2*CW]);

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff   <= req_x[CW-1] ? CW'(-req_x) : req_x;
         ay_ff   <= req_y[CW-1] ? CW'(-req_y) : req_y;
         z_ff    <= req_z;
         flag_ff <= {req_z[CW-1] || (req_z == '0), req_y[CW-1], req_x[CW-1]};
      end
   end

   // ---------------- x/z, y/z ----------------
   logic [NW-1:0] qx, qy;

   ppd_div #(.NW(NW), .DW(CW)) u_div_x (
      .clock(clock), .en(en), .num({ax_ff, {F{1'b0}}}), .den(z_ff), .quo(qx));
   ppd_div #(.NW(NW), .DW(CW)) u_div_y (
      .clock(clock), .en(en), .num({ay_ff, {F{1'b0}}}), .den(z_ff), .quo(qy));
   ppd_delay #(.W(3), .DEPTH(NW)) u_dly_flag (
      .clock(clock), .en(en), .d(flag_ff), .q(flag_div));

   // quotient clamp and sign
   logic [127:0]     qx_ext, qy_ext;
   logic             satqx, satqy;
   logic [MAG_W-1:0] magx, magy;
   val_type          x_ff, y_ff;
   logic             s1_ff;

   assign qx_ext = 128'(qx);
   assign qy_ext = 128'(qy);
   assign satqx  = qx_ext > 128'(LIM_MAG);
   assign satqy  = qy_ext > 128'(LIM_MAG);
   assign magx   = satqx ? LIM_MAG : qx_ext[MAG_W-1:0];
   assign magy   = satqy ? LIM_MAG : qy_ext[MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= flag_div[0] ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
         y_ff  <= flag_div[1] ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
         s1_ff <= satqx | satqy;
      end
   end

   // ---------------- squares and cross term ----------------
   val_type x2, y2, xy;
   logic    sat_x2, sat_y2, sat_xy, s1_d;

   ppd_fmul #(.FRAC(F)) u_mul_xx (
      .clock(clock), .en(en), .a(x_ff), .b(x_ff), .q(x2), .sat(sat_x2));
   ppd_fmul #(.FRAC(F)) u_mul_yy (
      .clock(clock), .en(en), .a(y_ff), .b(y_ff), .q(y2), .sat(sat_y2));
   ppd_fmul #(.FRAC(F)) u_mul_xy (
      .clock(clock), .en(en), .a(x_ff), .b(y_ff), .q(xy), .sat(sat_xy));
   ppd_delay #(.W(1), .DEPTH(ML)) u_dly_s1 (
      .clock(clock), .en(en), .d(s1_ff), .q(s1_d));

   // r2 = x2 + y2, xy2 = 2xy
   cval_type r2_c, xy2_c;
   val_type  r2_ff, xy2_ff, x2b_ff, y2b_ff;
   logic     s2_ff;

   assign r2_c  = clamp_val(64'(x2) + 64'(y2));
   assign xy2_c = clamp_val(64'(xy) + 64'(xy));

   always_ff @(posedge clock) begin
      if (en) begin
         r2_ff  <= r2_c.val;
         xy2_ff <= xy2_c.val;
         x2b_ff <= x2;
         y2b_ff <= y2;
         s2_ff  <= s1_d | sat_x2 | sat_y2 | sat_xy | r2_c.sat | xy2_c.sat;
      end
   end

   // tangential sums r2 + 2x2, r2 + 2y2
   cval_type t1_c, t2_c;
   val_type  t1_ff, t2_ff;
   logic     s3_ff;

   assign t1_c = clamp_val(64'(r2_ff) + 64'(x2b_ff) + 64'(x2b_ff));
   assign t2_c = clamp_val(64'(r2_ff) + 64'(y2b_ff) + 64'(y2b_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff <= t1_c.val;
         t2_ff <= t2_c.val;
         s3_ff <= s2_ff | t1_c.sat | t2_c.sat;
      end
   end

   // ---------------- radial factor ----------------
   val_type k1v, k2v, p1v, p2v, fxv, fyv;
   val_type r4, k1r2, k1r2_d, k2r4;
   logic    sat_r4, sat_k1r2, sat_k2r4, sat_r4_d, sat_k1r2_d, s3_d;

   assign k1v = VAL_W'(k1_ff);
   assign k2v = VAL_W'(k2_ff);
   assign p1v = VAL_W'(p1_ff);
   assign p2v = VAL_W'(p2_ff);
   assign fxv = VAL_W'(fx_ff);
   assign fyv = VAL_W'(fy_ff);

   ppd_fmul #(.FRAC(F)) u_mul_r4 (
      .clock(clock), .en(en), .a(r2_ff), .b(r2_ff), .q(r4), .sat(sat_r4));
   ppd_fmul #(.FRAC(F)) u_mul_k1 (
      .clock(clock), .en(en), .a(k1v), .b(r2_ff), .q(k1r2), .sat(sat_k1r2));
   ppd_fmul #(.FRAC(F)) u_mul_k2 (
      .clock(clock), .en(en), .a(k2v), .b(r4), .q(k2r4), .sat(sat_k2r4));
   ppd_delay #(.W(VAL_W+2), .DEPTH(ML)) u_dly_k1 (
      .clock(clock), .en(en), .d({k1r2, sat_k1r2, sat_r4}),
      .q({k1r2_d, sat_k1r2_d, sat_r4_d}));
   ppd_delay #(.W(1), .DEPTH(2*ML-1)) u_dly_s3 (
      .clock(clock), .en(en), .d(s3_ff), .q(s3_d));

   cval_type d_c;
   val_type  d_ff;
   logic     s4_ff;

   assign d_c = clamp_val((64'sd1 <<< F) + 64'(k1r2_d) + 64'(k2r4));

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff  <= d_c.val;
         s4_ff <= s3_d | sat_r4_d | sat_k1r2_d | sat_k2r4 | d_c.sat;
      end
   end

   // ---------------- distorted coordinates ----------------
   val_type xe, ye, xy2e, t1e, t2e;
   val_type m_xd, m_p1xy, m_p2t1, m_yd, m_p2xy, m_p1t2;
   logic    [5:0] sat_m;
   logic    s4_d;

   ppd_delay #(.W(2*VAL_W), .DEPTH(3*ML+2)) u_dly_xy (
      .clock(clock), .en(en), .d({x_ff, y_ff}), .q({xe, ye}));
   ppd_delay #(.W(VAL_W), .DEPTH(2*ML+1)) u_dly_xy2 (
      .clock(clock), .en(en), .d(xy2_ff), .q(xy2e));
   ppd_delay #(.W(2*VAL_W), .DEPTH(2*ML)) u_dly_t (
      .clock(clock), .en(en), .d({t1_ff, t2_ff}), .q({t1e, t2e}));

   ppd_fmul #(.FRAC(F)) u_mul_xd (
      .clock(clock), .en(en), .a(xe), .b(d_ff), .q(m_xd), .sat(sat_m[0]));
   ppd_fmul #(.FRAC(F)) u_mul_p1xy (
      .clock(clock), .en(en), .a(p1v), .b(xy2e), .q(m_p1xy), .sat(sat_m[1]));
   ppd_fmul #(.FRAC(F)) u_mul_p2t1 (
      .clock(clock), .en(en), .a(p2v), .b(t1e), .q(m_p2t1), .sat(sat_m[2]));
   ppd_fmul #(.FRAC(F)) u_mul_yd (
      .clock(clock), .en(en), .a(ye), .b(d_ff), .q(m_yd), .sat(sat_m[3]));
   ppd_fmul #(.FRAC(F)) u_mul_p2xy (
      .clock(clock), .en(en), .a(p2v), .b(xy2e), .q(m_p2xy), .sat(sat_m[4]));
   ppd_fmul #(.FRAC(F)) u_mul_p1t2 (
      .clock(clock), .en(en), .a(p1v), .b(t2e), .q(m_p1t2), .sat(sat_m[5]));
   ppd_delay #(.W(1), .DEPTH(ML)) u_dly_s4 (
      .clock(clock), .en(en), .d(s4_ff), .q(s4_d));

   cval_type dx_c, dy_c;
   val_type  dx_ff, dy_ff;
   logic     s5_ff;

   assign dx_c = clamp_val(64'(m_xd) + 64'(m_p1xy) + 64'(m_p2t1));
   assign dy_c = clamp_val(64'(m_yd) + 64'(m_p2xy) + 64'(m_p1t2));

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= dx_c.val;
         dy_ff <= dy_c.val;
         s5_ff <= s4_d | (|sat_m) | dx_c.sat | dy_c.sat;
      end
   end

   // ---------------- pixel mapping ----------------
   val_type mu, mv;
   logic    sat_mu, sat_mv, s5_d, bad_d;

   ppd_fmul #(.FRAC(F)) u_mul_fx (
      .clock(clock), .en(en), .a(fxv), .b(dx_ff), .q(mu), .sat(sat_mu));
   ppd_fmul #(.FRAC(F)) u_mul_fy (
      .clock(clock), .en(en), .a(fyv), .b(dy_ff), .q(mv), .sat(sat_mv));
   ppd_delay #(.W(1), .DEPTH(ML)) u_dly_s5 (
      .clock(clock), .en(en), .d(s5_ff), .q(s5_d));
   ppd_delay #(.W(1), .DEPTH(5*ML+4)) u_dly_bad (
      .clock(clock), .en(en), .d(flag_div[2]), .q(bad_d));

   logic [CW-1:0] u_ff, v_ff, u_in, v_in;
   logic          inv_ff, inv_in;

   always_comb begin
      logic signed [63:0] pu;
      logic signed [63:0] pv;
      logic               su;
      logic               sv;
      pu = 64'(mu) + 64'(cx_ff);
      pv = 64'(mv) + 64'(cy_ff);
      su = (pu > CMAX) || (pu < CMIN);
      sv = (pv > CMAX) || (pv < CMIN);
      if (pu > CMAX) begin
         pu = CMAX;
      end else if (pu < CMIN) begin
         pu = CMIN;
      end
      if (pv > CMAX) begin
         pv = CMAX;
      end else if (pv < CMIN) begin
         pv = CMIN;
      end
      if (bad_d) begin
         u_in   = '0;
         v_in   = '0;
         inv_in = 1'b1;
      end else begin
         u_in   = CW'(pu);
         v_in   = CW'(pv);
         inv_in = s5_d | sat_mu | sat_mv | su | sv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff   <= u_in;
         v_ff   <= v_in;
         inv_ff <= inv_in;
      end
   end

   assign rsp_tdata = RSP_W'({v_ff, u_ff});
   assign rsp_tuser = inv_ff;

   // ---------------- checks ----------------
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(vld_ff))
      else $error("pipe moved while the output was stalled");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted item not entered in the pipe");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (vld_ff == '0))
      else $error("pipe not empty after reset");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import ppd_pkg::*;

   localparam int FRAC = 28;
   localparam longint LIMV = 64'sh0FFF_FFFF_FFFF_FFFF;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 120;

   typedef struct packed {
      logic signed [31:0] z;
      logic signed [31:0] y;
      logic signed [31:0] x;
   } point_t;

   typedef struct packed {
      logic               invalid;
      logic signed [31:0] v;
      logic signed [31:0] u;
   } pixel_t;

   logic        clock;
   logic        reset;
   logic [95:0] req_tdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_we;
   logic [CFG_ADDR_W-1:0] csr_addr;
   logic [CFG_W-1:0]      csr_wdata;

   // shadow of the register file, only changed while the block is idle
   logic [31:0] regs [8];

   point_t  points_to_send [$];
   pixel_t  pixels_due [$];
   int      send_gap_pct;
   int      recv_stall_pct;
   int      fail_count;
   int      quiet_cycles;

   project_point_with_lens_distortion_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------
   // fixed-point helpers: sign plus magnitude, clamped to +-(2^60-1)
   // ---------------------------------------------------------------
   function automatic longint clamp_q(input longint v, inout bit sat);
      if (v > LIMV) begin
         sat = 1'b1;
         return LIMV;
      end
      if (v < -LIMV) begin
         sat = 1'b1;
         return -LIMV;
      end
      return v;
   endfunction

   // (a*b) >> FRAC with the magnitude truncated
   function automatic longint mul_q(input longint a, input longint b, inout bit sat);
      bit           neg;
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] prod;
      logic [127:0] q;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      prod = {64'd0, ma} * {64'd0, mb};
      q = prod >> FRAC;
      if (q > 128'(LIMV)) begin
         sat = 1'b1;
         q = 128'(LIMV);
      end
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   // (n << FRAC) / dz for dz > 0, truncated toward zero
   function automatic longint div_q(input longint n, input longint dz, inout bit sat);
      logic [127:0] mn;
      logic [127:0] q;
      mn = (n < 0) ? 128'(-n) : 128'(n);
      q = mn / 128'(dz);
      if (q > 128'(LIMV >>> FRAC)) begin
         sat = 1'b1;
         q = 128'(LIMV);
      end else begin
         q = (mn << FRAC) / 128'(dz);
         if (q > 128'(LIMV)) begin
            sat = 1'b1;
            q = 128'(LIMV);
         end
      end
      return (n < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic logic signed [31:0] place_pixel(input longint focal, input longint nd,
                                                      input longint centre, inout bit sat);
      longint p;
      p = mul_q(focal, nd, sat) + centre;
      if (p > 64'sd2147483647) begin
         sat = 1'b1;
         p = 64'sd2147483647;
      end
      if (p < -64'sd2147483648) begin
         sat = 1'b1;
         p = -64'sd2147483648;
      end
      return p[31:0];
   endfunction

   function automatic pixel_t project_point(input point_t pt);
      pixel_t px;
      bit     sat;
      longint k1, k2, p1, p2;
      longint x, y, x2, y2, xy, xy2, r2, r4, d, dx, dy;
      sat = 1'b0;
      px = '0;
      if (pt.z <= 0) begin
         px.invalid = 1'b1;
         return px;
      end
      k1 = longint'($signed(regs[REG_RADIAL_K1]));
      k2 = longint'($signed(regs[REG_RADIAL_K2]));
      p1 = longint'($signed(regs[REG_TANGENTIAL_P1]));
      p2 = longint'($signed(regs[REG_TANGENTIAL_P2]));
      x = div_q(longint'(pt.x), longint'(pt.z), sat);
      y = div_q(longint'(pt.y), longint'(pt.z), sat);
      x2 = mul_q(x, x, sat);
      y2 = mul_q(y, y, sat);
      xy = mul_q(x, y, sat);
      xy2 = clamp_q(xy + xy, sat);
      r2 = clamp_q(x2 + y2, sat);
      r4 = mul_q(r2, r2, sat);
      d = clamp_q((64'sd1 <<< FRAC) + mul_q(k1, r2, sat) + mul_q(k2, r4, sat), sat);
      dx = clamp_q(mul_q(x, d, sat) + mul_q(p1, xy2, sat)
                   + mul_q(p2, clamp_q(r2 + x2 + x2, sat), sat), sat);
      dy = clamp_q(mul_q(y, d, sat) + mul_q(p2, xy2, sat)
                   + mul_q(p1, clamp_q(r2 + y2 + y2, sat), sat), sat);
      px.u = place_pixel(longint'({32'd0, regs[REG_FOCAL_X]}), dx,
                         longint'($signed(regs[REG_CENTER_X])), sat);
      px.v = place_pixel(longint'({32'd0, regs[REG_FOCAL_Y]}), dy,
                         longint'($signed(regs[REG_CENTER_Y])), sat);
      px.invalid = sat;
      return px;
   endfunction

   // ---------------------------------------------------------------
   // driver: offers the next queued point, holds it until taken
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready)
            pixels_due.push_back(project_point(point_t'(req_tdata)));
         if (!req_tvalid || req_tready) begin
            if (points_to_send.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
               req_tdata  <= points_to_send.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: random back-pressure, checks each item against the oldest
   // prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      pixel_t want;
      pixel_t got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (pixels_due.size() == 0) begin
               $error("unexpected pixel item u=%0d v=%0d invalid=%0b", got.u, got.v,
                      got.invalid);
               fail_count++;
            end else begin
               want = pixels_due.pop_front();
               if (got.u !== want.u) begin
                  $error("pixel_u expected %0d got %0d", want.u, got.u);
                  fail_count++;
               end
               if (got.v !== want.v) begin
                  $error("pixel_v expected %0d got %0d", want.v, got.v);
                  fail_count++;
               end
               if (got.invalid !== want.invalid) begin
                  $error("invalid expected %0b got %0b", want.invalid, got.invalid);
                  fail_count++;
               end
            end
         end
      end
   end

   // watchdog: only counts while work is outstanding
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (points_to_send.size() == 0 && !req_tvalid && pixels_due.size() == 0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      regs[idx] = val;
   endtask

   task automatic load_regs(input logic [31:0] fx, input logic [31:0] fy,
                            input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] k1, input logic [31:0] k2,
                            input logic [31:0] p1, input logic [31:0] p2);
      write_reg(REG_FOCAL_X, fx);
      write_reg(REG_FOCAL_Y, fy);
      write_reg(REG_CENTER_X, cx);
      write_reg(REG_CENTER_Y, cy);
      write_reg(REG_RADIAL_K1, k1);
      write_reg(REG_RADIAL_K2, k2);
      write_reg(REG_TANGENTIAL_P1, p1);
      write_reg(REG_TANGENTIAL_P2, p2);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] sym_rand(input int unsigned span);
      return $urandom_range(2 * span) - span;
   endfunction

   task automatic queue_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
      point_t pt;
      pt.x = x;
      pt.y = y;
      pt.z = z;
      points_to_send.push_back(pt);
   endtask

   // mostly lens-like points in front of the camera, some noise
   task automatic queue_random_points(input int count);
      int unsigned z;
      int          kind;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(99);
         if (kind < 75) begin
            z = $urandom_range(32'h0001_0000, 32'h0064_0000);
            queue_point(sym_rand(z), sym_rand(z), z);
         end else if (kind < 85) begin
            // depth not positive
            queue_point($urandom, $urandom, ($urandom_range(3) == 0) ? 32'd0
                        : (32'h8000_0000 | $urandom));
         end else begin
            queue_point($urandom, $urandom, $urandom);
         end
      end
   endtask

   task automatic lens_like_regs();
      load_regs($urandom_range(200, 1000) << 16, $urandom_range(200, 1000) << 16,
                $urandom_range(0, 640) << 16, $urandom_range(0, 480) << 16,
                sym_rand(1 << 27), sym_rand(1 << 25), sym_rand(1 << 22), sym_rand(1 << 22));
   endtask

   task automatic wait_idle();
      while (points_to_send.size() > 0 || req_tvalid || pixels_due.size() > 0)
         @(posedge clock);
      // an in-flight item always produces a result, but keep a margin anyway
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_we       = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      fail_count   = 0;
      send_gap_pct = 0;
      recv_stall_pct = 0;
      regs[REG_FOCAL_X] = 32'h0001_0000;
      regs[REG_FOCAL_Y] = 32'h0001_0000;
      for (int r = REG_CENTER_X; r <= REG_TANGENTIAL_P2; r++)
         regs[r] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed points with the reset registers: unit and zero points,
      // field extremes, depth zero / negative, overflow of x/z
      queue_point(32'd0, 32'd0, 32'h0001_0000);
      queue_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      queue_point(32'hFFFF_0000, 32'h0002_0000, 32'h0004_0000);
      queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
      queue_point(32'h8000_0000, 32'h8000_0000, 32'd1);
      queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_point(32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      queue_point(32'h0001_0000, 32'd0, 32'd0);
      queue_point(32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF);
      queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_point(32'h0000_4000, 32'h0000_4000, 32'd1);
      queue_point(32'h0200_0000, 32'h0000_0000, 32'h0000_0010);
      queue_point(32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001);
      wait_idle();

      // register settings, idling mode changes with each one
      for (int phase = 0; phase < 8; phase++) begin
         send_gap_pct   = (phase % 4 == 1 || phase % 4 == 3) ? ((phase % 4 == 1) ? 80 : 33) : 0;
         recv_stall_pct = (phase % 4 == 2 || phase % 4 == 3) ? ((phase % 4 == 2) ? 80 : 33) : 0;
         case (phase)
            0, 4, 7: begin
               lens_like_regs();
            end
            1: begin
               // largest values everywhere
               load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            end
            2: begin
               // zero focal, most negative everything else
               load_regs(32'd0, 32'd0, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            end
            default: begin
               load_regs($urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
            end
         endcase
         if (phase == 1 || phase == 2) begin
            queue_point(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
            queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
            queue_point(32'd0, 32'd0, 32'h7FFF_FFFF);
         end
         queue_random_points(210);
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
